// ===== rtl/flvnal_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flvnal_pkg
// parse phases, stream constants and the result record of the flv nal extractor
// ----------------------------------------------------------------------------
package flvnal_pkg;

  typedef enum logic [3:0] {
    PH_FILE_HDR  = 4'd0,
    PH_HDR_SKIP  = 4'd1,
    PH_TAG_HDR   = 4'd2,
    PH_SKIP_BODY = 4'd3,
    PH_VID_CODEC = 4'd4,
    PH_PKT_TYPE  = 4'd5,
    PH_CTS_CFG   = 4'd6,
    PH_CTS_NAL   = 4'd7,
    PH_CONFIG    = 4'd8,
    PH_NAL_LEN   = 4'd9,
    PH_NAL_DATA  = 4'd10,
    PH_DISCARD   = 4'd11
  } phase_t;

  localparam logic [7:0]  SIG_F        = 8'h46;
  localparam logic [7:0]  SIG_L        = 8'h4c;
  localparam logic [7:0]  SIG_V        = 8'h56;
  localparam logic [7:0]  TAG_VIDEO    = 8'd9;
  localparam logic [3:0]  CODEC_AVC    = 4'd7;
  localparam logic [3:0]  FRAME_KEY    = 4'd1;
  localparam logic [7:0]  PKT_SEQ_HDR  = 8'd0;
  localparam logic [31:0] FILE_HDR_LEN = 32'd9;
  localparam logic [31:0] TAG_HDR_LAST = 32'd14;
  localparam logic [31:0] CTS_LAST     = 32'd2;
  localparam logic [31:0] LEN_LAST     = 32'd3;
  localparam logic        KIND_NAL     = 1'b0;
  localparam logic        KIND_CONFIG  = 1'b1;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        first_of_unit;
    logic        last_of_unit;
    logic        unit_kind;
    logic        key_frame;
    logic [31:0] timestamp;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/flv_tag_h264_nal_extractor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flv_tag_h264_nal_extractor
// walks an flv byte stream and emits the h.264 nal unit and config bytes
// ----------------------------------------------------------------------------
// channel | direction | beat
// in_     | input     | one file byte with its stream start mark
// out_    | output    | one payload byte with unit marks, kind, key flag, time
//
// one byte is taken every cycle while in_ready is high; the parse state
// updates at the accepting edge and a payload byte is registered into the
// output register, or the skid register while out_ stalls; both registers keep
// input going while out_ stalls; in_ready drops only when both are occupied
// rst_n (synchronous) clears the parser to the file signature phase
// ----------------------------------------------------------------------------
module flv_tag_h264_nal_extractor
  import flvnal_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_stream_start,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_payload_byte,
  output logic             out_first_of_unit,
  output logic             out_last_of_unit,
  output logic             out_unit_kind,
  output logic             out_key_frame,
  output logic [31:0]      out_timestamp
);

  phase_t      phase_r, phase_nxt, c_phase;
  logic [31:0] cnt_r, cnt_nxt, c_cnt;
  logic [31:0] hlen_r, hlen_nxt, c_hlen;
  logic [7:0]  ttype_r, ttype_nxt, c_ttype;
  logic [23:0] body_r, body_nxt, c_body;
  logic [31:0] ttime_r, ttime_nxt, c_ttime;
  logic [23:0] cts_r, cts_nxt, c_cts;
  logic [31:0] unit_r, unit_nxt, c_unit;
  logic        key_r, key_nxt, c_key;

  logic        in_fire;
  logic        emit;
  result_t     res;
  logic [31:0] cnt_inc;
  logic [31:0] hlen_sh;
  logic [31:0] unit_sh;
  logic [31:0] unit_dec;
  logic [23:0] body_dec;
  logic [31:0] stamp;

  result_t     out_r, out_nxt, skid_r, skid_nxt;
  logic        out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;

  // stream start views the state as freshly reset
  always_comb begin
    if (in_stream_start) begin
      c_phase = PH_FILE_HDR;
      c_cnt   = '0;
      c_hlen  = '0;
      c_ttype = '0;
      c_body  = '0;
      c_ttime = '0;
      c_cts   = '0;
      c_unit  = '0;
      c_key   = 1'b0;
    end else begin
      c_phase = phase_r;
      c_cnt   = cnt_r;
      c_hlen  = hlen_r;
      c_ttype = ttype_r;
      c_body  = body_r;
      c_ttime = ttime_r;
      c_cts   = cts_r;
      c_unit  = unit_r;
      c_key   = key_r;
    end
  end

  assign cnt_inc  = c_cnt + 32'd1;
  assign hlen_sh  = {c_hlen[23:0], in_data_byte};
  assign unit_sh  = {c_unit[23:0], in_data_byte};
  assign unit_dec = c_unit - 32'd1;
  assign body_dec = c_body - 24'd1;
  assign stamp    = c_ttime + {{8{c_cts[23]}}, c_cts};

  always_comb begin
    phase_nxt = c_phase;
    cnt_nxt   = c_cnt;
    hlen_nxt  = c_hlen;
    ttype_nxt = c_ttype;
    body_nxt  = c_body;
    ttime_nxt = c_ttime;
    cts_nxt   = c_cts;
    unit_nxt  = c_unit;
    key_nxt   = c_key;
    emit      = 1'b0;
    res.payload_byte  = in_data_byte;
    res.first_of_unit = (c_cnt == 32'd0);
    res.last_of_unit  = (c_body == 24'd1);
    res.unit_kind     = KIND_CONFIG;
    res.key_frame     = c_key;
    res.timestamp     = stamp;
    case (c_phase)
      PH_FILE_HDR: begin
        if ((c_cnt == 32'd0 && in_data_byte != SIG_F) ||
            (c_cnt == 32'd1 && in_data_byte != SIG_L) ||
            (c_cnt == 32'd2 && in_data_byte != SIG_V)) begin
          phase_nxt = PH_DISCARD;
        end else begin
          if (c_cnt >= 32'd5) begin
            hlen_nxt = hlen_sh;
          end
          cnt_nxt = cnt_inc;
          if (cnt_inc >= FILE_HDR_LEN) begin
            if (hlen_nxt > FILE_HDR_LEN) begin
              cnt_nxt   = hlen_nxt - FILE_HDR_LEN;
              phase_nxt = PH_HDR_SKIP;
            end else begin
              cnt_nxt   = '0;
              phase_nxt = PH_TAG_HDR;
            end
          end
        end
      end
      PH_HDR_SKIP: begin
        cnt_nxt = c_cnt - 32'd1;
        if (cnt_nxt == 32'd0) begin
          phase_nxt = PH_TAG_HDR;
        end
      end
      PH_TAG_HDR: begin
        case (c_cnt[3:0])
          4'd4:         ttype_nxt = in_data_byte;
          4'd5:         body_nxt  = {16'd0, in_data_byte};
          4'd6, 4'd7:   body_nxt  = {c_body[15:0], in_data_byte};
          4'd8:         ttime_nxt = {24'd0, in_data_byte};
          4'd9, 4'd10:  ttime_nxt = {c_ttime[23:0], in_data_byte};
          4'd11:        ttime_nxt = {in_data_byte, c_ttime[23:0]};
          default:      ;
        endcase
        cnt_nxt = cnt_inc;
        if (c_cnt >= TAG_HDR_LAST) begin
          cnt_nxt = '0;
          if (c_body == 24'd0) begin
            phase_nxt = PH_TAG_HDR;
          end else if (c_ttype == TAG_VIDEO) begin
            phase_nxt = PH_VID_CODEC;
          end else begin
            phase_nxt = PH_SKIP_BODY;
          end
        end
      end
      PH_DISCARD: ;
      default: begin
        case (c_phase)
          PH_VID_CODEC: begin
            key_nxt   = (in_data_byte[7:4] == FRAME_KEY);
            phase_nxt = (in_data_byte[3:0] == CODEC_AVC) ? PH_PKT_TYPE : PH_SKIP_BODY;
          end
          PH_PKT_TYPE: begin
            phase_nxt = (in_data_byte == PKT_SEQ_HDR) ? PH_CTS_CFG : PH_CTS_NAL;
            cts_nxt   = '0;
            cnt_nxt   = '0;
          end
          PH_CTS_CFG, PH_CTS_NAL: begin
            cts_nxt = {c_cts[15:0], in_data_byte};
            cnt_nxt = cnt_inc;
            if (c_cnt >= CTS_LAST) begin
              cnt_nxt   = '0;
              unit_nxt  = '0;
              phase_nxt = (c_phase == PH_CTS_CFG) ? PH_CONFIG : PH_NAL_LEN;
            end
          end
          PH_CONFIG: begin
            emit    = 1'b1;
            cnt_nxt = 32'd1;
          end
          PH_NAL_LEN: begin
            unit_nxt = unit_sh;
            cnt_nxt  = cnt_inc;
            if (c_cnt >= LEN_LAST) begin
              cnt_nxt = '0;
              if (unit_sh != 32'd0) begin
                phase_nxt = PH_NAL_DATA;
              end
            end
          end
          PH_NAL_DATA: begin
            emit              = 1'b1;
            res.unit_kind     = KIND_NAL;
            res.last_of_unit  = (c_unit == 32'd1) || (c_body == 24'd1);
            cnt_nxt           = 32'd1;
            unit_nxt          = unit_dec;
            if (unit_dec == 32'd0) begin
              cnt_nxt   = '0;
              phase_nxt = PH_NAL_LEN;
            end
          end
          default: ;
        endcase
        body_nxt = body_dec;
        if (body_dec == 24'd0) begin
          cnt_nxt   = '0;
          unit_nxt  = '0;
          phase_nxt = PH_TAG_HDR;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FILE_HDR;
      cnt_r   <= '0;
      hlen_r  <= '0;
      ttype_r <= '0;
      body_r  <= '0;
      ttime_r <= '0;
      cts_r   <= '0;
      unit_r  <= '0;
      key_r   <= 1'b0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      hlen_r  <= hlen_nxt;
      ttype_r <= ttype_nxt;
      body_r  <= body_nxt;
      ttime_r <= ttime_nxt;
      cts_r   <= cts_nxt;
      unit_r  <= unit_nxt;
      key_r   <= key_nxt;
    end
  end

  // output register with skid stage
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end
    if (in_fire && emit) begin
      if (out_valid_r && !out_ready) begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end else begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_payload_byte  = out_r.payload_byte;
  assign out_first_of_unit = out_r.first_of_unit;
  assign out_last_of_unit  = out_r.last_of_unit;
  assign out_unit_kind     = out_r.unit_kind;
  assign out_key_frame     = out_r.key_frame;
  assign out_timestamp     = out_r.timestamp;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid beat held without an output beat");

  a_nal_len_live: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_NAL_DATA |-> unit_r != 32'd0)
    else $error("nal data phase with no bytes left in the unit");

  a_body_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_FILE_HDR && phase_r != PH_HDR_SKIP &&
     phase_r != PH_TAG_HDR && phase_r != PH_DISCARD) |-> body_r != 24'd0)
    else $error("body phase with an empty tag body");

  a_skip_live: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HDR_SKIP |-> cnt_r != 32'd0)
    else $error("header skip with zero count");

  a_discard_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_stream_start && phase_r == PH_DISCARD |=> phase_r == PH_DISCARD)
    else $error("left discard without stream start");
`endif

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the flv h.264 nal extractor against a byte-level parse of the stream
// ----------------------------------------------------------------------------
// builds flv files: well-formed tags with random content, with broken
// signatures, cut files and odd tags mixed in
// every accepted input beat is parsed here as well; each payload beat on out_
// is compared field by field with the oldest predicted beat
// both sides idle at random in two mixes, then run flat out with one long
// receiver hold-off
// ----------------------------------------------------------------------------
module tb_top;
  import flvnal_pkg::*;

  localparam int ITEM_TARGET  = 2000;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } file_byte_t;

  class nal_stream_tracker;
    phase_t      ph;
    logic [31:0] byte_cnt;
    logic [31:0] hdr_len;
    logic [7:0]  tag_kind;
    logic [23:0] body_left;
    logic [31:0] tag_ts;
    logic [23:0] cts;
    logic [31:0] nal_left;
    logic        key;
    logic        sig_bad;
    result_t     payload_q[$];
    int          errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      ph       = PH_FILE_HDR;
      byte_cnt = '0;
      hdr_len  = '0;
      tag_kind = '0;
      body_left = '0;
      tag_ts   = '0;
      cts      = '0;
      nal_left = '0;
      key      = 1'b0;
      sig_bad  = 1'b0;
    endfunction

    function void queue_payload(logic [7:0] b, logic first, logic last, logic kind);
      result_t r;
      r.payload_byte  = b;
      r.first_of_unit = first;
      r.last_of_unit  = last;
      r.unit_kind     = kind;
      r.key_frame     = key;
      r.timestamp     = tag_ts + {{8{cts[23]}}, cts};
      payload_q.insert(payload_q.size(), r);
    endfunction

    function void take_file_byte(logic [7:0] b, logic start);
      logic [31:0] i;
      if (start) clear();
      i = byte_cnt;
      case (ph)
        PH_FILE_HDR: begin
          if ((i == 0 && b != SIG_F) || (i == 1 && b != SIG_L) || (i == 2 && b != SIG_V)) begin
            sig_bad = 1'b1;
            ph = PH_DISCARD;
          end else begin
            if (i >= 5) hdr_len = {hdr_len[23:0], b};
            byte_cnt = i + 1;
            if (i + 1 >= FILE_HDR_LEN) begin
              byte_cnt = '0;
              if (hdr_len > FILE_HDR_LEN) begin
                byte_cnt = hdr_len - FILE_HDR_LEN;
                ph = PH_HDR_SKIP;
              end else begin
                ph = PH_TAG_HDR;
              end
            end
          end
        end
        PH_HDR_SKIP: begin
          byte_cnt = byte_cnt - 1;
          if (byte_cnt == 0) ph = PH_TAG_HDR;
        end
        PH_TAG_HDR: begin
          case (i)
            4: tag_kind = b;
            5: body_left = {16'd0, b};
            6, 7: body_left = {body_left[15:0], b};
            8: tag_ts = {24'd0, b};
            9, 10: tag_ts = {tag_ts[23:0], b};
            11: tag_ts = {b, tag_ts[23:0]};
            default: ;
          endcase
          byte_cnt = i + 1;
          if (i >= TAG_HDR_LAST) begin
            byte_cnt = '0;
            if (body_left == 0) ph = PH_TAG_HDR;
            else if (tag_kind == TAG_VIDEO) ph = PH_VID_CODEC;
            else ph = PH_SKIP_BODY;
          end
        end
        PH_DISCARD: ;
        default: begin
          case (ph)
            PH_VID_CODEC: begin
              key = (b[7:4] == FRAME_KEY);
              if (b[3:0] == CODEC_AVC) ph = PH_PKT_TYPE;
              else ph = PH_SKIP_BODY;
            end
            PH_PKT_TYPE: begin
              if (b == PKT_SEQ_HDR) ph = PH_CTS_CFG;
              else ph = PH_CTS_NAL;
              cts = '0;
              byte_cnt = '0;
            end
            PH_CTS_CFG, PH_CTS_NAL: begin
              cts = {cts[15:0], b};
              byte_cnt = byte_cnt + 1;
              if (byte_cnt > CTS_LAST) begin
                byte_cnt = '0;
                nal_left = '0;
                if (ph == PH_CTS_CFG) ph = PH_CONFIG;
                else ph = PH_NAL_LEN;
              end
            end
            PH_CONFIG: begin
              queue_payload(b, byte_cnt == 0, body_left == 1, KIND_CONFIG);
              byte_cnt = 32'd1;
            end
            PH_NAL_LEN: begin
              nal_left = {nal_left[23:0], b};
              byte_cnt = byte_cnt + 1;
              if (byte_cnt > LEN_LAST) begin
                byte_cnt = '0;
                if (nal_left != 0) ph = PH_NAL_DATA;
              end
            end
            PH_NAL_DATA: begin
              queue_payload(b, byte_cnt == 0, nal_left == 1 || body_left == 1, KIND_NAL);
              byte_cnt = 32'd1;
              nal_left = nal_left - 1;
              if (nal_left == 0) begin
                byte_cnt = '0;
                ph = PH_NAL_LEN;
              end
            end
            default: ;
          endcase
          body_left = body_left - 24'd1;
          if (body_left == 0) begin
            byte_cnt = '0;
            nal_left = '0;
            ph = PH_TAG_HDR;
          end
        end
      endcase
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_payload(result_t got);
      result_t want;
      if (payload_q.size() == 0) begin
        $error("payload beat %0h arrived with none predicted", got.payload_byte);
        errors++;
        return;
      end
      want = payload_q.pop_front();
      cmp_field("payload_byte", want.payload_byte, got.payload_byte);
      cmp_field("first_of_unit", want.first_of_unit, got.first_of_unit);
      cmp_field("last_of_unit", want.last_of_unit, got.last_of_unit);
      cmp_field("unit_kind", want.unit_kind, got.unit_kind);
      cmp_field("key_frame", want.key_frame, got.key_frame);
      cmp_field("timestamp", want.timestamp, got.timestamp);
    endfunction

    function int outstanding();
      return payload_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_stream_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_payload_byte;
  logic        out_first_of_unit;
  logic        out_last_of_unit;
  logic        out_unit_kind;
  logic        out_key_frame;
  logic [31:0] out_timestamp;

  nal_stream_tracker tracker;
  file_byte_t        stim_q[$];
  int                idle_mode = 0;

  flv_tag_h264_nal_extractor u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_stream_start   (in_stream_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_payload_byte  (out_payload_byte),
    .out_first_of_unit (out_first_of_unit),
    .out_last_of_unit  (out_last_of_unit),
    .out_unit_kind     (out_unit_kind),
    .out_key_frame     (out_key_frame),
    .out_timestamp     (out_timestamp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int send_idle_pct();
    case (idle_mode)
      0: return 31;
      1: return 46;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct();
    case (idle_mode)
      0: return 46;
      1: return 31;
      default: return 0;
    endcase
  endfunction

  task automatic put(logic [7:0] b, logic start);
    file_byte_t fb;
    fb.data  = b;
    fb.start = start;
    stim_q.insert(stim_q.size(), fb);
  endtask

  task automatic put_be(logic [31:0] v, int n);
    for (int k = n - 1; k >= 0; k--) put(v[8*k +: 8], 1'b0);
  endtask

  task automatic tag_head(logic [7:0] kind, logic [23:0] len, logic [31:0] ts);
    put_be($urandom, 4);
    put(kind, 1'b0);
    put_be({8'd0, len}, 3);
    put_be({8'd0, ts[23:0]}, 3);
    put(ts[31:24], 1'b0);
    put_be($urandom, 3);
  endtask

  task automatic build_directed();
    // bad signature, then a discarded byte
    put(8'h00, 1'b1);
    put(8'hff, 1'b0);
    // header length below the minimum
    put(SIG_F, 1'b1);
    put(SIG_L, 1'b0);
    put(SIG_V, 1'b0);
    put(8'h01, 1'b0);
    put(8'h05, 1'b0);
    put_be(32'd3, 4);
    // key frame: zero length, one-byte unit, two-byte unit, negative offset
    tag_head(TAG_VIDEO, 24'd20, 32'hff00_0002);
    put({FRAME_KEY, CODEC_AVC}, 1'b0);
    put(8'h01, 1'b0);
    put_be(32'h00ff_fffd, 3);
    put_be(32'd0, 4);
    put_be(32'd1, 4);
    put(8'h80, 1'b0);
    put_be(32'd2, 4);
    put(8'hff, 1'b0);
    put(8'h00, 1'b0);
    // config record with the largest positive offset
    tag_head(TAG_VIDEO, 24'd7, 32'd0);
    put({4'd2, CODEC_AVC}, 1'b0);
    put(PKT_SEQ_HDR, 1'b0);
    put_be(32'h007f_ffff, 3);
    put(8'h01, 1'b0);
    put(8'h80, 1'b0);
    // empty config record
    tag_head(TAG_VIDEO, 24'd5, 32'd1);
    put({FRAME_KEY, CODEC_AVC}, 1'b0);
    put(PKT_SEQ_HDR, 1'b0);
    put_be(32'd0, 3);
    // other codec, audio, empty script tag, body ending inside the prefix
    tag_head(TAG_VIDEO, 24'd3, 32'd0);
    put(8'h12, 1'b0);
    put(8'haa, 1'b0);
    put(8'h55, 1'b0);
    tag_head(8'd8, 24'd2, 32'd0);
    put(8'haf, 1'b0);
    put(8'h01, 1'b0);
    tag_head(8'd18, 24'd0, 32'd0);
    tag_head(TAG_VIDEO, 24'd2, 32'd0);
    put({FRAME_KEY, CODEC_AVC}, 1'b0);
    put(8'h01, 1'b0);
    // unit longer than its tag
    tag_head(TAG_VIDEO, 24'd12, 32'd5);
    put({FRAME_KEY, CODEC_AVC}, 1'b0);
    put(8'h01, 1'b0);
    put_be(32'd0, 3);
    put_be(32'd100, 4);
    put(8'h11, 1'b0);
    put(8'h22, 1'b0);
    put(8'h33, 1'b0);
    // length prefix cut by the tag end
    tag_head(TAG_VIDEO, 24'd7, 32'd5);
    put({4'd3, CODEC_AVC}, 1'b0);
    put(8'h01, 1'b0);
    put_be(32'd0, 3);
    put(8'h00, 1'b0);
    put(8'h00, 1'b0);
  endtask

  task automatic gen_tag();
    logic [7:0]  body[$];
    logic [7:0]  kind;
    logic [3:0]  ft;
    logic [31:0] nlen;
    int          sel, cnt, codec, cut;
    sel  = $urandom_range(99);
    kind = TAG_VIDEO;
    if (sel < 65) begin
      ft = $urandom_range(1) ? FRAME_KEY : 4'($urandom_range(15));
      body.insert(body.size(), {ft, CODEC_AVC});
      if ($urandom_range(3) == 0) body.insert(body.size(), PKT_SEQ_HDR);
      else if ($urandom_range(2) == 0) body.insert(body.size(), 8'($urandom_range(1, 255)));
      else body.insert(body.size(), 8'd1);
      repeat (3) body.insert(body.size(), 8'($urandom));
      if (body[1] == PKT_SEQ_HDR) begin
        repeat ($urandom_range(0, 12)) body.insert(body.size(), 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(19) == 0) nlen = $urandom;
          else nlen = $urandom_range(0, 10);
          for (int k = 3; k >= 0; k--) body.insert(body.size(), nlen[8*k +: 8]);
          cnt = (nlen > 10) ? $urandom_range(0, 8) : int'(nlen);
          repeat (cnt) body.insert(body.size(), 8'($urandom));
        end
      end
    end else if (sel < 73) begin
      codec = $urandom_range(0, 14);
      if (codec >= CODEC_AVC) codec++;
      body.insert(body.size(), {4'($urandom), 4'(codec)});
      repeat ($urandom_range(0, 8)) body.insert(body.size(), 8'($urandom));
    end else begin
      case ($urandom_range(2))
        0: kind = 8'd8;
        1: kind = 8'd18;
        default: kind = 8'($urandom);
      endcase
      if (kind == TAG_VIDEO) kind = 8'd8;
      repeat ($urandom_range(0, 10)) body.insert(body.size(), 8'($urandom));
    end
    if ($urandom_range(6) == 0) begin
      cut = $urandom_range(0, body.size());
      while (body.size() > cut) void'(body.pop_back());
    end
    tag_head(kind, 24'(body.size()), $urandom);
    foreach (body[k]) put(body[k], 1'b0);
  endtask

  task automatic gen_random_file();
    int         mark, hlen, sig_pos, r, cut;
    logic [7:0] sb;
    if ($urandom_range(11) == 0) begin
      sig_pos = $urandom_range(0, 2);
      for (int k = 0; k <= sig_pos; k++) begin
        sb = (k == 0) ? SIG_F : (k == 1) ? SIG_L : SIG_V;
        if (k == sig_pos) sb = sb ^ 8'($urandom_range(1, 255));
        put(sb, k == 0);
      end
      repeat ($urandom_range(0, 6)) put(8'($urandom), 1'b0);
      return;
    end
    mark = stim_q.size();
    r = $urandom_range(9);
    if (r < 6) hlen = 9;
    else if (r < 8) hlen = $urandom_range(10, 16);
    else hlen = $urandom_range(0, 8);
    put(SIG_F, 1'b1);
    put(SIG_L, 1'b0);
    put(SIG_V, 1'b0);
    put(8'($urandom), 1'b0);
    put(8'($urandom), 1'b0);
    put_be(hlen, 4);
    if (hlen > 9) repeat (hlen - 9) put(8'($urandom), 1'b0);
    repeat ($urandom_range(1, 6)) gen_tag();
    if ($urandom_range(9) == 0) begin
      cut = $urandom_range(mark + 1, stim_q.size() - 1);
      while (stim_q.size() > cut) void'(stim_q.pop_back());
    end
  endtask

  task automatic drive_bytes();
    int total;
    total = stim_q.size();
    for (int idx = 0; idx < total; idx++) begin
      idle_mode = idx * 3 / total;
      if ($urandom_range(99) < send_idle_pct()) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while ($urandom_range(99) < send_idle_pct()) @(posedge clk);
      end
      in_valid        <= 1'b1;
      in_data_byte    <= stim_q[idx].data;
      in_stream_start <= stim_q[idx].start;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid <= 1'b0;
  endtask

  // receiver: random stalls, one long hold-off when the flat-out mix starts
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (idle_mode == 2 && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct());
    end
  end

  always @(posedge clk) begin : beat_monitor
    result_t seen;
    if (rst_n) begin
      if (in_valid && in_ready) tracker.take_file_byte(in_data_byte, in_stream_start);
      if (out_valid && out_ready) begin
        seen.payload_byte  = out_payload_byte;
        seen.first_of_unit = out_first_of_unit;
        seen.last_of_unit  = out_last_of_unit;
        seen.unit_kind     = out_unit_kind;
        seen.key_frame     = out_key_frame;
        seen.timestamp     = out_timestamp;
        tracker.check_payload(seen);
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    tracker = new();
    build_directed();
    while (stim_q.size() < ITEM_TARGET) gen_random_file();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    drive_bytes();
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
